// ===== sv/dim_pkg.sv =====
package dim_pkg;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_COST_BITS    = 16;
    localparam int CFG_ADDR_W       = 2;

    typedef enum logic [1:0] {
        CMD_RESTART = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_RELAX   = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_RANGE = 2'd2
    } status_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_NUM_VERTICES  = 2'd0,
        REG_ORIGIN        = 2'd1,
        REG_DESTINATION   = 2'd2,
        REG_MAX_EDGE_COST = 2'd3
    } reg_idx_t;

    // Controller states; the current state is also the command to the datapath.
    typedef enum logic [22:0] {
        ST_IDLE   = 23'h000001,
        ST_SWEEP  = 23'h000002,
        ST_RS_ORG = 23'h000004,
        ST_SU_A   = 23'h000008,
        ST_SU_B   = 23'h000010,
        ST_SU_C   = 23'h000020,
        ST_SU_END = 23'h000040,
        ST_EX_A   = 23'h000080,
        ST_EX_B   = 23'h000100,
        ST_EX_C   = 23'h000200,
        ST_EX_D   = 23'h000400,
        ST_SD_A   = 23'h000800,
        ST_SD_B   = 23'h001000,
        ST_SD_C   = 23'h002000,
        ST_SD_D   = 23'h004000,
        ST_SD_E   = 23'h008000,
        ST_SD_END = 23'h010000,
        ST_RX_A   = 23'h020000,
        ST_RX_B   = 23'h040000,
        ST_RX_C   = 23'h080000,
        ST_RD_A   = 23'h100000,
        ST_RD_B   = 23'h200000,
        ST_FIN    = 23'h400000
    } state_t;

    typedef struct packed {
        state_t op;
        logic   load;
        logic   emit;
    } ctrl_t;

    typedef struct packed {
        cmd_t new_cmd;
        cmd_t cmd;
        logic n_zero;
        logic sweep_last;
        logic origin_ok;
        logic s_zero;
        logic up_less;
        logic zero_count;
        logic no_child;
        logic has_sib;
        logic sd_stop;
        logic range_bad;
        logic relax_ok;
        logic out_free;
    } stat_t;

endpackage

// ===== sv/dijkstra_indexed_min_heap.sv =====
// Channel   Direction  Fields, lowest bit first
// s_*       in         cmd, from_vertex, to_vertex, edge_cost
// m_*       out        vertex, cost, father, found, updated, heap_left, status
// cfg_*     in         register index, write data
//
// One request is worked on at a time. Restart sweeps the n vertex entries and then sifts
// the origin up the heap (no sift when the origin is out of range); extract sifts the last
// entry down level by level; relax sifts the improved vertex up; read and a rejected
// request need no heap walk.
// The result sits in an output register, so the next request is taken while it waits, but
// that request holds in its final state until the register frees. Each table has one write
// and one registered read port. Reset empties the heap and loads the register defaults.
module dijkstra_indexed_min_heap #(
    parameter int MAX_VERTICES = dim_pkg::DEF_MAX_VERTICES,
    parameter int COST_BITS    = dim_pkg::DEF_COST_BITS,
    localparam int VW   = $clog2(MAX_VERTICES),
    localparam int NW   = VW + 1,
    localparam int CFGW = (NW > COST_BITS) ? NW : COST_BITS,
    localparam int INW  = 2 + 2 * VW + COST_BITS,
    localparam int OUTW = 2 * VW + COST_BITS + NW + 4,
    localparam int INB  = ((INW + 7) / 8) * 8,
    localparam int OUTB = ((OUTW + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // cmd, from_vertex, to_vertex, edge_cost, then zero fill
    input  logic [INB-1:0]                 s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // vertex, cost, father, found, updated, heap_left, status, then zero fill
    output logic [OUTB-1:0]                m_tdata,
    input  logic                           cfg_we,
    input  logic [dim_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFGW-1:0]                cfg_data
);

    dim_pkg::ctrl_t  ctrl;
    dim_pkg::stat_t  st;
    logic [OUTW-1:0] out_data;

    // The controller sequences each request; its state is the datapath command.
    dim_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .ctrl     (ctrl)
    );

    // The datapath holds the four vertex tables, the heap count and the result.
    dim_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COST_BITS    (COST_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .st        (st),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata[INW-1:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = OUTB'(out_data);

endmodule

// ===== sv/dim_ram.sv =====
module dim_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/dim_ctrl.sv =====
module dim_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  dim_pkg::stat_t  st,
    output dim_pkg::ctrl_t  ctrl
);

    dim_pkg::state_t state_reg;
    dim_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dim_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dim_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (st.new_cmd)
                        dim_pkg::CMD_RESTART:
                            state_next = st.n_zero ? dim_pkg::ST_RS_ORG : dim_pkg::ST_SWEEP;
                        dim_pkg::CMD_EXTRACT:
                            state_next = dim_pkg::ST_EX_A;
                        default:
                            state_next = dim_pkg::ST_RX_A;
                    endcase
                end
            end
            dim_pkg::ST_SWEEP:
                state_next = st.sweep_last ? dim_pkg::ST_RS_ORG : dim_pkg::ST_SWEEP;
            dim_pkg::ST_RS_ORG:
                state_next = st.origin_ok ? dim_pkg::ST_SU_A : dim_pkg::ST_FIN;
            dim_pkg::ST_SU_A:
                state_next = st.s_zero ? dim_pkg::ST_SU_END : dim_pkg::ST_SU_B;
            dim_pkg::ST_SU_B:
                state_next = dim_pkg::ST_SU_C;
            dim_pkg::ST_SU_C:
                state_next = st.up_less ? dim_pkg::ST_SU_A : dim_pkg::ST_SU_END;
            dim_pkg::ST_SU_END:
                state_next = dim_pkg::ST_FIN;
            dim_pkg::ST_EX_A:
                state_next = st.zero_count ? dim_pkg::ST_FIN : dim_pkg::ST_EX_B;
            dim_pkg::ST_EX_B:
                state_next = dim_pkg::ST_EX_C;
            dim_pkg::ST_EX_C:
                state_next = dim_pkg::ST_EX_D;
            dim_pkg::ST_EX_D:
                state_next = dim_pkg::ST_SD_A;
            dim_pkg::ST_SD_A:
                state_next = st.no_child ? dim_pkg::ST_SD_END : dim_pkg::ST_SD_B;
            dim_pkg::ST_SD_B:
                state_next = dim_pkg::ST_SD_C;
            dim_pkg::ST_SD_C:
                state_next = st.has_sib ? dim_pkg::ST_SD_D : dim_pkg::ST_SD_E;
            dim_pkg::ST_SD_D:
                state_next = dim_pkg::ST_SD_E;
            dim_pkg::ST_SD_E:
                state_next = st.sd_stop ? dim_pkg::ST_SD_END : dim_pkg::ST_SD_A;
            dim_pkg::ST_SD_END:
                state_next = dim_pkg::ST_RD_A;
            dim_pkg::ST_RX_A:
            begin
                if (st.range_bad)
                begin
                    state_next = dim_pkg::ST_FIN;
                end
                else if (st.cmd == dim_pkg::CMD_READ)
                begin
                    state_next = dim_pkg::ST_RD_A;
                end
                else
                begin
                    state_next = dim_pkg::ST_RX_B;
                end
            end
            dim_pkg::ST_RX_B:
                state_next = dim_pkg::ST_RX_C;
            dim_pkg::ST_RX_C:
                state_next = st.relax_ok ? dim_pkg::ST_SU_A : dim_pkg::ST_RD_A;
            dim_pkg::ST_RD_A:
                state_next = dim_pkg::ST_RD_B;
            dim_pkg::ST_RD_B:
                state_next = dim_pkg::ST_FIN;
            dim_pkg::ST_FIN:
                state_next = st.out_free ? dim_pkg::ST_IDLE : dim_pkg::ST_FIN;
            default:
                state_next = dim_pkg::ST_IDLE;
        endcase
    end

    assign s_tready  = (state_reg == dim_pkg::ST_IDLE);
    assign ctrl.op   = state_reg;
    assign ctrl.load = (state_reg == dim_pkg::ST_IDLE) && s_tvalid;
    assign ctrl.emit = (state_reg == dim_pkg::ST_FIN) && st.out_free;

endmodule

// ===== sv/dim_dpath.sv =====
module dim_dpath #(
    parameter int MAX_VERTICES = dim_pkg::DEF_MAX_VERTICES,
    parameter int COST_BITS    = dim_pkg::DEF_COST_BITS,
    localparam int VW   = $clog2(MAX_VERTICES),
    localparam int NW   = VW + 1,
    localparam int CW   = COST_BITS,
    localparam int CFGW = (NW > CW) ? NW : CW,
    localparam int INW  = 2 + 2 * VW + CW,
    localparam int OUTW = 2 * VW + CW + NW + 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dim_pkg::ctrl_t                ctrl,
    output dim_pkg::stat_t                st,
    input  logic                          cfg_we,
    input  logic [dim_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFGW-1:0]               cfg_data,
    input  logic [INW-1:0]                in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [OUTW-1:0]               out_data
);

    localparam logic [CW-1:0] InfCost  = {CW{1'b1}};
    localparam logic [NW-1:0] MaxCount = NW'(MAX_VERTICES);

    // Configuration and control state.
    logic [NW-1:0] num_vertices_reg;
    logic [VW-1:0] origin_reg;
    logic [VW-1:0] destination_reg;
    logic [CW-1:0] max_edge_cost_reg;
    logic [NW-1:0] count_reg;
    logic          out_valid_reg;

    // Working registers.
    dim_pkg::cmd_t cmd_reg;
    logic [VW-1:0] from_reg, to_reg, idx_reg, s_reg, mv_reg, pv_reg, top_reg;
    logic [VW-1:0] ps_reg, cv_reg, dv_reg, cand_v_reg, cand_s_reg, tgt_reg;
    logic [CW-1:0] ecost_reg, mk_reg, base_reg, cand_k_reg;

    // Result being assembled.
    logic [VW-1:0]     res_vertex_reg, res_father_reg;
    logic [CW-1:0]     res_cost_reg;
    logic              res_found_reg, res_updated_reg;
    dim_pkg::status_t  res_status_reg;
    logic [OUTW-1:0]   out_data_reg;

    // Memory ports.
    logic          cost_we, pred_we, pos_we, vis_we;
    logic [VW-1:0] cost_wa, pred_wa, pos_wa, vis_wa;
    logic [VW-1:0] cost_ra, pred_ra, pos_ra, vis_ra;
    logic [CW-1:0] cost_wd, cost_rd;
    logic [VW-1:0] pred_wd, pos_wd, vis_wd, pred_rd, pos_rd, vis_rd;

    logic [NW-1:0] n_eff;
    logic [VW-1:0] par_slot;
    logic [VW:0]   c_slot;
    logic [VW+1:0] c1_slot;
    logic [CW:0]   sum;
    logic          cost_inf, member;

    dim_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_cost (
        .clk(clk), .we(cost_we), .waddr(cost_wa), .wdata(cost_wd),
        .raddr(cost_ra), .rdata(cost_rd)
    );
    dim_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_pred (
        .clk(clk), .we(pred_we), .waddr(pred_wa), .wdata(pred_wd),
        .raddr(pred_ra), .rdata(pred_rd)
    );
    dim_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_pos (
        .clk(clk), .we(pos_we), .waddr(pos_wa), .wdata(pos_wd),
        .raddr(pos_ra), .rdata(pos_rd)
    );
    dim_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vis (
        .clk(clk), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd),
        .raddr(vis_ra), .rdata(vis_rd)
    );

    assign n_eff    = (num_vertices_reg > MaxCount) ? MaxCount : num_vertices_reg;
    assign par_slot = VW'((s_reg - VW'(1)) >> 1);
    assign c_slot   = {s_reg, 1'b1};
    assign c1_slot  = {1'b0, c_slot} + (VW+2)'(1);
    assign sum      = {1'b0, base_reg} + {1'b0, ecost_reg};
    assign cost_inf = (cost_rd == InfCost);
    assign member   = ({1'b0, ps_reg} < count_reg) && (vis_rd == to_reg);

    assign st.new_cmd    = dim_pkg::cmd_t'(in_data[1:0]);
    assign st.cmd        = cmd_reg;
    assign st.n_zero     = (n_eff == '0);
    assign st.sweep_last = ({1'b0, idx_reg} == (n_eff - NW'(1)));
    assign st.origin_ok  = ({1'b0, origin_reg} < n_eff);
    assign st.s_zero     = (s_reg == '0);
    assign st.up_less    = (mk_reg < cost_rd);
    assign st.zero_count = (count_reg == '0);
    assign st.no_child   = (c_slot >= count_reg);
    assign st.has_sib    = (c1_slot < {1'b0, count_reg});
    assign st.sd_stop    = (mk_reg < cand_k_reg);
    assign st.range_bad  = ({1'b0, to_reg} >= n_eff) ||
                           ((cmd_reg == dim_pkg::CMD_RELAX) && ({1'b0, from_reg} >= n_eff));
    assign st.relax_ok   = member && (ecost_reg <= max_edge_cost_reg) &&
                           (base_reg != InfCost) && (sum < {1'b0, cost_rd});
    assign st.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        cost_we = 1'b0; cost_wa = '0; cost_wd = '0; cost_ra = '0;
        pred_we = 1'b0; pred_wa = '0; pred_wd = '0; pred_ra = '0;
        pos_we  = 1'b0; pos_wa  = '0; pos_wd  = '0; pos_ra  = '0;
        vis_we  = 1'b0; vis_wa  = '0; vis_wd  = '0; vis_ra  = '0;
        case (ctrl.op)
            dim_pkg::ST_SWEEP:
            begin
                cost_we = 1'b1; cost_wa = idx_reg; cost_wd = InfCost;
                pred_we = 1'b1; pred_wa = idx_reg; pred_wd = '0;
                pos_we  = 1'b1; pos_wa  = idx_reg; pos_wd  = idx_reg;
                vis_we  = 1'b1; vis_wa  = idx_reg; vis_wd  = idx_reg;
            end
            dim_pkg::ST_RS_ORG:
            begin
                if (st.origin_ok)
                begin
                    cost_we = 1'b1; cost_wa = origin_reg; cost_wd = '0;
                    pred_we = 1'b1; pred_wa = origin_reg; pred_wd = origin_reg;
                end
            end
            dim_pkg::ST_SU_A:
                vis_ra = par_slot;
            dim_pkg::ST_SU_B, dim_pkg::ST_EX_C, dim_pkg::ST_SD_C:
                cost_ra = vis_rd;
            dim_pkg::ST_SU_C:
            begin
                if (st.up_less)
                begin
                    vis_we = 1'b1; vis_wa = s_reg;  vis_wd = pv_reg;
                    pos_we = 1'b1; pos_wa = pv_reg; pos_wd = s_reg;
                end
            end
            dim_pkg::ST_SU_END, dim_pkg::ST_SD_END:
            begin
                vis_we = 1'b1; vis_wa = s_reg;  vis_wd = mv_reg;
                pos_we = 1'b1; pos_wa = mv_reg; pos_wd = s_reg;
            end
            dim_pkg::ST_EX_A:
                vis_ra = '0;
            dim_pkg::ST_EX_B:
                vis_ra = count_reg[VW-1:0];
            dim_pkg::ST_SD_A:
                vis_ra = st.no_child ? '0 : c_slot[VW-1:0];
            dim_pkg::ST_SD_B:
            begin
                cost_ra = vis_rd;
                vis_ra  = st.has_sib ? c1_slot[VW-1:0] : '0;
            end
            dim_pkg::ST_SD_E:
            begin
                if (!st.sd_stop)
                begin
                    vis_we = 1'b1; vis_wa = s_reg;      vis_wd = cand_v_reg;
                    pos_we = 1'b1; pos_wa = cand_v_reg; pos_wd = s_reg;
                end
            end
            dim_pkg::ST_RX_A:
            begin
                cost_ra = from_reg;
                pos_ra  = to_reg;
            end
            dim_pkg::ST_RX_B:
            begin
                cost_ra = to_reg;
                vis_ra  = pos_rd;
            end
            dim_pkg::ST_RX_C:
            begin
                if (st.relax_ok)
                begin
                    cost_we = 1'b1; cost_wa = to_reg; cost_wd = sum[CW-1:0];
                    pred_we = 1'b1; pred_wa = to_reg; pred_wd = from_reg;
                end
            end
            dim_pkg::ST_RD_A:
            begin
                cost_ra = tgt_reg;
                pred_ra = tgt_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vertices_reg  <= NW'(1);
            origin_reg        <= '0;
            destination_reg   <= '0;
            max_edge_cost_reg <= {{(CW-1){1'b1}}, 1'b0};
            count_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (dim_pkg::reg_idx_t'(cfg_addr))
                    dim_pkg::REG_NUM_VERTICES:  num_vertices_reg  <= cfg_data[NW-1:0];
                    dim_pkg::REG_ORIGIN:        origin_reg        <= cfg_data[VW-1:0];
                    dim_pkg::REG_DESTINATION:   destination_reg   <= cfg_data[VW-1:0];
                    dim_pkg::REG_MAX_EDGE_COST: max_edge_cost_reg <= cfg_data[CW-1:0];
                    default: ;
                endcase
            end
            if (ctrl.op == dim_pkg::ST_RS_ORG)
            begin
                count_reg <= n_eff;
            end
            else if ((ctrl.op == dim_pkg::ST_EX_A) && !st.zero_count)
            begin
                count_reg <= count_reg - NW'(1);
            end
            if (ctrl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg   <= dim_pkg::cmd_t'(in_data[1:0]);
            from_reg  <= in_data[2 +: VW];
            to_reg    <= in_data[2 + VW +: VW];
            ecost_reg <= in_data[2 + 2 * VW +: CW];
            idx_reg   <= '0;
        end
        case (ctrl.op)
            dim_pkg::ST_SWEEP:
                idx_reg <= idx_reg + VW'(1);
            dim_pkg::ST_RS_ORG:
            begin
                s_reg           <= origin_reg;
                mv_reg          <= origin_reg;
                mk_reg          <= '0;
                res_vertex_reg  <= origin_reg;
                res_cost_reg    <= '0;
                res_father_reg  <= st.origin_ok ? origin_reg : '0;
                res_found_reg   <= 1'b0;
                res_updated_reg <= 1'b0;
                res_status_reg  <= st.origin_ok ? dim_pkg::STS_OK : dim_pkg::STS_RANGE;
            end
            dim_pkg::ST_SU_B:
                pv_reg <= vis_rd;
            dim_pkg::ST_SU_C:
            begin
                if (st.up_less)
                begin
                    s_reg <= par_slot;
                end
            end
            dim_pkg::ST_EX_A:
            begin
                res_vertex_reg  <= '0;
                res_cost_reg    <= '0;
                res_father_reg  <= '0;
                res_found_reg   <= 1'b0;
                res_updated_reg <= 1'b0;
                res_status_reg  <= dim_pkg::STS_EMPTY;
            end
            dim_pkg::ST_EX_B:
                top_reg <= vis_rd;
            dim_pkg::ST_EX_C:
            begin
                mv_reg <= vis_rd;
                s_reg  <= '0;
            end
            dim_pkg::ST_EX_D:
                mk_reg <= cost_rd;
            dim_pkg::ST_SD_B:
                cv_reg <= vis_rd;
            dim_pkg::ST_SD_C:
            begin
                cand_v_reg <= cv_reg;
                cand_k_reg <= cost_rd;
                cand_s_reg <= c_slot[VW-1:0];
                dv_reg     <= vis_rd;
            end
            dim_pkg::ST_SD_D:
            begin
                // Take the right child only when it is strictly cheaper.
                if (cand_k_reg > cost_rd)
                begin
                    cand_v_reg <= dv_reg;
                    cand_k_reg <= cost_rd;
                    cand_s_reg <= c1_slot[VW-1:0];
                end
            end
            dim_pkg::ST_SD_E:
            begin
                if (!st.sd_stop)
                begin
                    s_reg <= cand_s_reg;
                end
            end
            dim_pkg::ST_SD_END:
                tgt_reg <= top_reg;
            dim_pkg::ST_RX_A:
            begin
                tgt_reg         <= to_reg;
                res_vertex_reg  <= to_reg;
                res_cost_reg    <= '0;
                res_father_reg  <= '0;
                res_found_reg   <= 1'b0;
                res_updated_reg <= 1'b0;
                res_status_reg  <= dim_pkg::STS_RANGE;
            end
            dim_pkg::ST_RX_B:
            begin
                base_reg <= cost_rd;
                ps_reg   <= pos_rd;
            end
            dim_pkg::ST_RX_C:
            begin
                s_reg           <= ps_reg;
                mv_reg          <= to_reg;
                mk_reg          <= sum[CW-1:0];
                res_vertex_reg  <= to_reg;
                res_cost_reg    <= sum[CW-1:0];
                res_father_reg  <= from_reg;
                res_found_reg   <= 1'b0;
                res_updated_reg <= 1'b1;
                res_status_reg  <= dim_pkg::STS_OK;
            end
            dim_pkg::ST_RD_B:
            begin
                res_vertex_reg  <= tgt_reg;
                res_cost_reg    <= cost_rd;
                res_father_reg  <= cost_inf ? '0 : pred_rd;
                res_found_reg   <= (cmd_reg == dim_pkg::CMD_EXTRACT) &&
                                   (tgt_reg == destination_reg) && !cost_inf;
                res_updated_reg <= 1'b0;
                res_status_reg  <= dim_pkg::STS_OK;
            end
            default:
            begin
            end
        endcase
        if (ctrl.emit)
        begin
            out_data_reg <= {res_status_reg, count_reg, res_updated_reg, res_found_reg,
                             res_father_reg, res_cost_reg, res_vertex_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/dim_checker.sv =====
module dim_checker #(
    parameter int MAX_VERTICES = dim_pkg::DEF_MAX_VERTICES,
    parameter int COST_BITS    = dim_pkg::DEF_COST_BITS,
    localparam int VW   = $clog2(MAX_VERTICES),
    localparam int NW   = VW + 1,
    localparam int OUTW = 2 * VW + COST_BITS + NW + 4,
    localparam int OUTB = ((OUTW + 7) / 8) * 8,
    localparam int FOUND_B = 2 * VW + COST_BITS,
    localparam int UPD_B   = FOUND_B + 1,
    localparam int LEFT_B  = FOUND_B + 2,
    localparam int STS_B   = LEFT_B + NW
) (
    input logic            clk,
    input logic            rst_n,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic [OUTB-1:0] m_tdata
);

    logic [1:0]    sts;
    logic [NW-1:0] left;

    assign sts  = m_tdata[STS_B +: 2];
    assign left = m_tdata[LEFT_B +: NW];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_left: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> left <= NW'(MAX_VERTICES))
        else $error("heap count beyond vertex capacity");

    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[FOUND_B] |->
            sts == dim_pkg::STS_OK && !m_tdata[UPD_B])
        else $error("found flag on a failed or relax result");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && sts == dim_pkg::STS_EMPTY |-> left == '0)
        else $error("empty-heap status with vertices left");

endmodule

bind dijkstra_indexed_min_heap dim_checker #(
    .MAX_VERTICES (MAX_VERTICES),
    .COST_BITS    (COST_BITS)
) u_dim_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int NV      = 1024;
    localparam int INF     = 65535;
    localparam int IN_BITS = 40;
    localparam int OUT_BITS = 56;

    // One result of the shortest-path engine, packed so that it lines up with the
    // low 51 bits of m_tdata (vertex in the lowest bits, status in the highest).
    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] heap_left;
        logic        updated;
        logic        found;
        logic [9:0]  father;
        logic [15:0] cost;
        logic [9:0]  vertex;
    } res_t;

    // One row of the directed table. Rows with typed set carry a hand-written result.
    typedef struct {
        dim_pkg::cmd_t cmd;
        int    from_v;
        int    to_v;
        int    ecost;
        bit    typed;
        res_t  res;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    // cmd, from_vertex, to_vertex, edge_cost, then zero fill
    logic [IN_BITS-1:0]   s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // vertex, cost, father, found, updated, heap_left, status, then zero fill
    logic [OUT_BITS-1:0]  m_tdata;
    logic                 cfg_we;
    logic [dim_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [15:0]          cfg_data;

    dijkstra_indexed_min_heap DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Shadow copy of the engine: cost, predecessor and the two heap index tables.
    logic [15:0] cost_of[NV];
    logic [9:0]  father_of[NV];
    int          slot_of[NV];
    int          vertex_at[NV];
    int          heap_size;
    // Highest vertex count ever loaded by a restart; entries beyond it were never
    // written, so the stimulus never makes the engine read them.
    int          loaded;

    int          sh_nv;
    int          sh_origin;
    int          sh_dest;
    int          sh_maxcost;

    res_t        pending_results[$];
    int          errors;
    bit          idle_on;

    function automatic int eff_count();
        return (sh_nv > NV) ? NV : sh_nv;
    endfunction

    function automatic void swap_slots(int a, int b);
        int va;
        int vb;
        va = vertex_at[a];
        vb = vertex_at[b];
        vertex_at[a] = vb;
        vertex_at[b] = va;
        slot_of[vb] = a;
        slot_of[va] = b;
    endfunction

    function automatic void bubble_up(int s);
        int up;
        while (s > 0 && s < heap_size)
        begin
            up = (s - 1) / 2;
            if (!(cost_of[vertex_at[s]] < cost_of[vertex_at[up]]))
                break;
            swap_slots(s, up);
            s = up;
        end
    endfunction

    function automatic void bubble_down(int s);
        int c;
        while (2 * s + 1 < heap_size)
        begin
            c = 2 * s + 1;
            if (c + 1 < heap_size && cost_of[vertex_at[c]] > cost_of[vertex_at[c + 1]])
                c = c + 1;
            if (cost_of[vertex_at[s]] < cost_of[vertex_at[c]])
                break;
            swap_slots(c, s);
            s = c;
        end
    endfunction

    function automatic res_t vertex_report(int v);
        res_t r;
        r = '0;
        r.vertex = v[9:0];
        r.cost   = cost_of[v];
        r.father = (cost_of[v] == 16'hFFFF) ? 10'd0 : father_of[v];
        return r;
    endfunction

    // Computes the engine's answer to one request and updates the shadow state.
    function automatic res_t shortest_path_step(dim_pkg::cmd_t cmd, int from_v, int to_v,
                                                int ecost);
        res_t r;
        int   n;
        int   v;
        int   sum;
        r = '0;
        n = eff_count();
        case (cmd)
            dim_pkg::CMD_RESTART:
            begin
                for (int i = 0; i < n; i++)
                begin
                    slot_of[i]   = i;
                    vertex_at[i] = i;
                    cost_of[i]   = 16'hFFFF;
                    father_of[i] = '0;
                end
                heap_size = n;
                if (n > loaded)
                    loaded = n;
                if (sh_origin < n)
                begin
                    cost_of[sh_origin]   = '0;
                    father_of[sh_origin] = sh_origin[9:0];
                    bubble_up(slot_of[sh_origin]);
                    r = vertex_report(sh_origin);
                end
                else
                begin
                    r.vertex = sh_origin[9:0];
                    r.status = dim_pkg::STS_RANGE;
                end
            end
            dim_pkg::CMD_EXTRACT:
            begin
                if (heap_size == 0)
                    r.status = dim_pkg::STS_EMPTY;
                else
                begin
                    v = vertex_at[0];
                    swap_slots(0, heap_size - 1);
                    heap_size = heap_size - 1;
                    bubble_down(0);
                    r = vertex_report(v);
                    r.found = (v == sh_dest && cost_of[v] != 16'hFFFF);
                end
            end
            default:
            begin
                if (to_v >= n || (cmd == dim_pkg::CMD_RELAX && from_v >= n))
                begin
                    r.vertex = to_v[9:0];
                    r.status = dim_pkg::STS_RANGE;
                end
                else
                begin
                    if (cmd == dim_pkg::CMD_RELAX)
                    begin
                        sum = int'(cost_of[from_v]) + ecost;
                        // Only a member of the heap, reached from a reached source by an
                        // allowed edge, and only when the new path is strictly shorter.
                        if (slot_of[to_v] < heap_size && vertex_at[slot_of[to_v]] == to_v
                            && ecost <= sh_maxcost && cost_of[from_v] != 16'hFFFF
                            && sum < int'(cost_of[to_v]))
                        begin
                            father_of[to_v] = from_v[9:0];
                            cost_of[to_v]   = sum[15:0];
                            bubble_up(slot_of[to_v]);
                            r.updated = 1'b1;
                        end
                    end
                    r = vertex_report(to_v) | (r & res_t'({2'b0, 11'b0, 1'b1, 37'b0}));
                end
            end
        endcase
        r.heap_left = heap_size[10:0];
        return r;
    endfunction

    function automatic res_t mk_res(int v, int c, int f, int fd, int up, int hl,
                                    dim_pkg::status_t st);
        res_t r;
        r.vertex    = v[9:0];
        r.cost      = c[15:0];
        r.father    = f[9:0];
        r.found     = fd[0];
        r.updated   = up[0];
        r.heap_left = hl[10:0];
        r.status    = st;
        return r;
    endfunction

    function automatic row_t mk_row(dim_pkg::cmd_t c, int f, int t, int e, bit typed,
                                    res_t r);
        row_t w;
        w.cmd    = c;
        w.from_v = f;
        w.to_v   = t;
        w.ecost  = e;
        w.typed  = typed;
        w.res    = r;
        return w;
    endfunction

    // Register writes happen only while the engine is idle; the shadow copy follows.
    task automatic set_registers(int nv, int org, int dst, int mc);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= dim_pkg::REG_NUM_VERTICES;
        cfg_data <= nv[15:0];
        @(negedge clk);
        cfg_addr <= dim_pkg::REG_ORIGIN;
        cfg_data <= org[15:0];
        @(negedge clk);
        cfg_addr <= dim_pkg::REG_DESTINATION;
        cfg_data <= dst[15:0];
        @(negedge clk);
        cfg_addr <= dim_pkg::REG_MAX_EDGE_COST;
        cfg_data <= mc[15:0];
        @(negedge clk);
        cfg_we   <= 1'b0;
        sh_nv      = nv & 16'h7FF;
        sh_origin  = org & 16'h3FF;
        sh_dest    = dst & 16'h3FF;
        sh_maxcost = mc;
    endtask

    // Presents one request, waits for its handshake and files the expected result.
    task automatic send_request(dim_pkg::cmd_t cmd, int from_v, int to_v, int ecost,
                                bit typed, res_t typed_res);
        int   gap;
        res_t predicted;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 13);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b0, ecost[15:0], to_v[9:0], from_v[9:0], cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = shortest_path_step(cmd, from_v, to_v, ecost);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Withdraws the request line so the last request is not taken twice, then waits.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // A vertex inside the count but never loaded by a restart must not be touched.
    function automatic int legal_vertex(int v);
        if (v < eff_count() && v >= loaded)
            return $urandom_range(0, loaded - 1);
        return v;
    endfunction

    function automatic int pick_vertex();
        int n;
        n = (eff_count() < loaded) ? eff_count() : loaded;
        if ($urandom_range(0, 9) == 0 || n == 0)
            return legal_vertex($urandom_range(0, 1023));
        return $urandom_range(0, n - 1);
    endfunction

    // Mostly relaxations out of reached vertices mixed with extractions, as a real
    // search issues them, with some reads, restarts and out-of-range requests.
    task automatic random_phase(int count);
        int   pick;
        int   f;
        int   t;
        int   e;
        dim_pkg::cmd_t c;
        send_request(dim_pkg::CMD_RESTART, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 65534), 1'b0, '0);
        for (int k = 1; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            f = pick_vertex();
            t = pick_vertex();
            if (pick < 4)
                c = dim_pkg::CMD_RESTART;
            else if (pick < 34)
                c = dim_pkg::CMD_EXTRACT;
            else if (pick < 85)
            begin
                c = dim_pkg::CMD_RELAX;
                for (int tries = 0; tries < 4 && cost_of[f] == 16'hFFFF; tries++)
                    f = pick_vertex();
            end
            else
                c = dim_pkg::CMD_READ;
            case ($urandom_range(0, 9))
                0:       e = 0;
                1:       e = 65534;
                2:       e = $urandom_range(0, 65534);
                3:       e = sh_maxcost;
                default: e = $urandom_range(0, 60);
            endcase
            send_request(c, f, t, e, 1'b0, '0);
        end
    endtask

    // Result checker: every accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = res_t'(m_tdata[50:0]);
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result vertex=%0d cost=%0d status=%0d",
                         $time, got.vertex, got.cost, got.status);
                errors = errors + 1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch expected v=%0d c=%0d f=%0d fd=%0d up=%0d hl=%0d st=%0d",
                             $time, want.vertex, want.cost, want.father, want.found,
                             want.updated, want.heap_left, want.status);
                    $display("%0t:          actual   v=%0d c=%0d f=%0d fd=%0d up=%0d hl=%0d st=%0d",
                             $time, got.vertex, got.cost, got.father, got.found,
                             got.updated, got.heap_left, got.status);
                    errors = errors + 1;
                end
            end
        end
    end

    // Result side back-pressure: random bursts of stall, none while idle_on is low.
    always @(negedge clk)
    begin
        int stall_left;
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left = $urandom_range(1, 13) - 1;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        #2000000;
        $display("** dijkstra_indexed_min_heap: FAILED **");
        $finish;
    end

    initial
    begin
        row_t rows[$];
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = dim_pkg::REG_NUM_VERTICES;
        cfg_data   = '0;
        rst_n      = 1'b0;
        errors     = 0;
        idle_on    = 1'b1;
        heap_size  = 0;
        loaded     = 0;
        sh_nv      = 1;
        sh_origin  = 0;
        sh_dest    = 0;
        sh_maxcost = 65534;
        for (int i = 0; i < NV; i++)
        begin
            cost_of[i]   = '0;
            father_of[i] = '0;
            slot_of[i]   = 0;
            vertex_at[i] = 0;
        end
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset register values: one vertex, origin and
        // destination both vertex 0. Extract on an empty heap, out-of-range vertices,
        // the restart, a relax that does not improve, the reachable destination.
        rows.push_back(mk_row(dim_pkg::CMD_EXTRACT, 0, 0, 0, 1,
                              mk_res(0, 0, 0, 0, 0, 0, dim_pkg::STS_EMPTY)));
        rows.push_back(mk_row(dim_pkg::CMD_READ, 0, 5, 0, 1,
                              mk_res(5, 0, 0, 0, 0, 0, dim_pkg::STS_RANGE)));
        rows.push_back(mk_row(dim_pkg::CMD_RELAX, 0, 1023, 65534, 1,
                              mk_res(1023, 0, 0, 0, 0, 0, dim_pkg::STS_RANGE)));
        rows.push_back(mk_row(dim_pkg::CMD_RESTART, 1023, 1023, 65534, 1,
                              mk_res(0, 0, 0, 0, 0, 1, dim_pkg::STS_OK)));
        rows.push_back(mk_row(dim_pkg::CMD_READ, 1023, 0, 0, 1,
                              mk_res(0, 0, 0, 0, 0, 1, dim_pkg::STS_OK)));
        rows.push_back(mk_row(dim_pkg::CMD_RELAX, 0, 0, 0, 1,
                              mk_res(0, 0, 0, 0, 0, 1, dim_pkg::STS_OK)));
        rows.push_back(mk_row(dim_pkg::CMD_RELAX, 1023, 0, 0, 1,
                              mk_res(0, 0, 0, 0, 0, 1, dim_pkg::STS_RANGE)));
        rows.push_back(mk_row(dim_pkg::CMD_EXTRACT, 0, 0, 0, 1,
                              mk_res(0, 0, 0, 1, 0, 0, dim_pkg::STS_OK)));
        rows.push_back(mk_row(dim_pkg::CMD_EXTRACT, 0, 0, 0, 1,
                              mk_res(0, 0, 0, 0, 0, 0, dim_pkg::STS_EMPTY)));
        rows.push_back(mk_row(dim_pkg::CMD_RELAX, 0, 0, 65534, 1,
                              mk_res(0, 0, 0, 0, 0, 0, dim_pkg::STS_OK)));
        foreach (rows[i])
            send_request(rows[i].cmd, rows[i].from_v, rows[i].to_v, rows[i].ecost,
                         rows[i].typed, rows[i].res);
        wait_drained();

        // Small graph: relax chain with an edge limit, then checked by the predictor.
        set_registers(6, 2, 5, 100);
        rows.delete();
        rows.push_back(mk_row(dim_pkg::CMD_RESTART, 0, 0, 0, 0, '0));
        rows.push_back(mk_row(dim_pkg::CMD_RELAX, 2, 4, 7, 0, '0));
        rows.push_back(mk_row(dim_pkg::CMD_RELAX, 2, 5, 101, 0, '0));
        rows.push_back(mk_row(dim_pkg::CMD_RELAX, 2, 5, 100, 0, '0));
        rows.push_back(mk_row(dim_pkg::CMD_RELAX, 4, 5, 3, 0, '0));
        rows.push_back(mk_row(dim_pkg::CMD_RELAX, 1, 3, 1, 0, '0));
        rows.push_back(mk_row(dim_pkg::CMD_READ, 0, 5, 0, 0, '0));
        rows.push_back(mk_row(dim_pkg::CMD_EXTRACT, 0, 0, 0, 0, '0));
        rows.push_back(mk_row(dim_pkg::CMD_RELAX, 4, 2, 0, 0, '0));
        rows.push_back(mk_row(dim_pkg::CMD_EXTRACT, 0, 0, 0, 0, '0));
        rows.push_back(mk_row(dim_pkg::CMD_EXTRACT, 0, 0, 0, 0, '0));
        rows.push_back(mk_row(dim_pkg::CMD_READ, 0, 3, 0, 0, '0));
        rows.push_back(mk_row(dim_pkg::CMD_READ, 0, 6, 0, 0, '0));
        foreach (rows[i])
            send_request(rows[i].cmd, rows[i].from_v, rows[i].to_v, rows[i].ecost,
                         rows[i].typed, rows[i].res);
        wait_drained();

        // Random phases over several register settings, the extremes among them.
        set_registers(12, 3, 9, 30);
        random_phase(90);
        wait_drained();
        set_registers(1, 0, 0, 0);
        random_phase(30);
        wait_drained();
        set_registers(1024, 1023, 1023, 65534);
        random_phase(12);
        wait_drained();
        set_registers(20, 40, 7, 500);
        random_phase(60);
        wait_drained();
        set_registers(33, 32, 0, 65534);
        random_phase(90);
        wait_drained();
        set_registers(9, 0, 8, 20);
        random_phase(90);
        wait_drained();

        // Last part of the run: no idling on either side.
        idle_on = 1'b0;
        set_registers(16, 5, 11, 40);
        random_phase(100);
        wait_drained();
        repeat (30) @(posedge clk);

        if (errors == 0)
            $display("** dijkstra_indexed_min_heap: PASSED **");
        else
            $display("** dijkstra_indexed_min_heap: FAILED **");
        $finish;
    end

endmodule
